FILE: src/tccb_pkg.sv
// Package for the text console cell buffer: sizes, codes, queue entry and result types.
// No dependencies.
package tccb_pkg;
  localparam int MaxRows = 32;
  localparam int MaxCols = 128;
  localparam int RowW = 5;
  localparam int ColW = 7;
  localparam int AddrW = RowW + ColW;
  localparam int Depth = MaxRows * MaxCols;

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChReturn = 8'd13;
  localparam logic [7:0] ChBackspace = 8'd8;

  localparam logic [2:0] ModePut = 3'd0;
  localparam logic [2:0] ModeDel = 3'd1;
  localparam logic [2:0] ModeIns = 3'd2;
  localparam logic [2:0] ModeClr = 3'd3;
  localparam logic [2:0] ModeMove = 3'd4;
  localparam logic [2:0] ModeRead = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP, OP_NEWLINE, OP_RETURN, OP_BACKSPACE, OP_PUT, OP_DEL, OP_INS, OP_CLR
  } op_t;
  // move and read are their own ops
  typedef enum logic [1:0] {OPX_NONE, OPX_MOVE, OPX_READ} opx_t;

  typedef struct packed {
    op_t op;
    opx_t opx;
    logic [7:0] ch;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic drawn_valid;
    logic [4:0] drawn_row;
    logic [6:0] drawn_col;
    logic [7:0] drawn_char;
    logic scrolled;
    logic [4:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] read_char;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SHIFT, S_ZERO, S_CLR, S_BSREAD, S_BSWAIT, S_BSCHK, S_RDWAIT,
    S_RDOUT, S_DONE, S_INIT
  } state_t;
endpackage

FILE: src/tccb_front.sv
// Front end: accepts input transfers, classifies them and queues commands.
// Depends on tccb_pkg.
module tccb_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] mode,
  input  logic [7:0] char_code,
  input  logic [4:0] row,
  input  logic [6:0] col,
  output logic q_valid,
  input  logic q_take,
  output tccb_pkg::cmd_t q_cmd
);
  tccb_pkg::cmd_t fifo [2];
  logic wp, rp;
  logic [1:0] cnt;
  tccb_pkg::cmd_t c;
  logic push, pop;

  always_comb begin
    c.ch = char_code;
    c.row = row;
    c.col = col;
    c.opx = tccb_pkg::OPX_NONE;
    c.op = tccb_pkg::OP_NOP;
    case (mode)
      tccb_pkg::ModePut: begin
        if (char_code == tccb_pkg::ChNewline) c.op = tccb_pkg::OP_NEWLINE;
        else if (char_code == tccb_pkg::ChReturn) c.op = tccb_pkg::OP_RETURN;
        else if (char_code == tccb_pkg::ChBackspace) c.op = tccb_pkg::OP_BACKSPACE;
        else c.op = tccb_pkg::OP_PUT;
      end
      tccb_pkg::ModeDel: c.op = tccb_pkg::OP_DEL;
      tccb_pkg::ModeIns: c.op = tccb_pkg::OP_INS;
      tccb_pkg::ModeClr: c.op = tccb_pkg::OP_CLR;
      tccb_pkg::ModeMove: c.opx = tccb_pkg::OPX_MOVE;
      tccb_pkg::ModeRead: c.opx = tccb_pkg::OPX_READ;
      default: c.op = tccb_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= c;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/tccb_back.sv
// Back end: row map, cursor and cell store; runs queued commands and holds the result.
// Depends on tccb_pkg.
module tccb_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  tccb_pkg::cmd_t q_cmd,
  input  logic [7:0] cols_reg,
  input  logic [5:0] rows_reg,
  output logic out_valid,
  input  logic out_stall,
  output tccb_pkg::res_t res
);
  localparam int RW = tccb_pkg::RowW;
  localparam int CW = tccb_pkg::ColW;

  logic [7:0] mem [tccb_pkg::Depth];
  logic [tccb_pkg::AddrW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic we;

  tccb_pkg::state_t state, state_next;
  tccb_pkg::cmd_t cmd, cmd_next;
  logic [RW-1:0] rmap [tccb_pkg::MaxRows];
  logic [RW-1:0] crow, crow_next;
  logic [7:0] ccol, ccol_next;
  logic [RW-1:0] idx, idx_next, last, last_next;
  logic [RW-1:0] phys, phys_next;
  logic [7:0] cnt, cnt_next;
  logic [tccb_pkg::AddrW-1:0] sweep, sweep_next;
  logic dir_del, dir_del_next;
  tccb_pkg::res_t r, r_next;
  logic ov, ov_next;
  logic map_shift, map_set;

  logic [7:0] nc;
  logic [5:0] nr;
  assign nc = (cols_reg == 8'd0) ? 8'd1 : (cols_reg > 8'd128) ? 8'd128 : cols_reg;
  assign nr = (rows_reg == 6'd0) ? 6'd1 : (rows_reg > 6'd32) ? 6'd32 : rows_reg;

  logic [RW-1:0] nrm1;
  assign nrm1 = RW'(nr - 6'd1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign out_valid = ov;
  assign res = r;

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    crow_next = crow;
    ccol_next = ccol;
    idx_next = idx;
    last_next = last;
    phys_next = phys;
    cnt_next = cnt;
    sweep_next = sweep;
    dir_del_next = dir_del;
    r_next = r;
    ov_next = ov;
    q_take = 1'b0;
    we = 1'b0;
    waddr = {phys, cnt[CW-1:0]};
    wdata = 8'd0;
    raddr = {rmap[crow], ccol[CW-1:0]};
    map_shift = 1'b0;
    map_set = 1'b0;
    if (ov && !out_stall) ov_next = 1'b0;
    case (state)
      tccb_pkg::S_INIT: begin
        we = 1'b1;
        waddr = sweep;
        sweep_next = sweep + 1'b1;
        if (sweep == '1) state_next = tccb_pkg::S_IDLE;
      end
      tccb_pkg::S_IDLE: begin
        if (q_valid && !(ov && out_stall)) begin
          q_take = 1'b1;
          cmd_next = q_cmd;
          if ({3'b0, crow} >= {2'b0, nr}) crow_next = nrm1;
          if (ccol > nc) ccol_next = nc;
          r_next = '0;
          state_next = tccb_pkg::S_DISP;
        end
      end
      tccb_pkg::S_DISP: begin
        state_next = tccb_pkg::S_DONE;
        case (cmd.opx)
          tccb_pkg::OPX_MOVE: begin
            if ({1'b0, cmd.row} < nr && {1'b0, cmd.col} < nc) begin
              crow_next = cmd.row;
              ccol_next = {1'b0, cmd.col};
            end
          end
          tccb_pkg::OPX_READ: begin
            raddr = {rmap[cmd.row], cmd.col};
            if ({1'b0, cmd.row} < nr && {1'b0, cmd.col} < nc)
              state_next = tccb_pkg::S_RDWAIT;
          end
          default: begin
            case (cmd.op)
              tccb_pkg::OP_NEWLINE, tccb_pkg::OP_PUT: begin
                if (cmd.op == tccb_pkg::OP_NEWLINE || ccol >= nc) begin
                  ccol_next = 8'd0;
                  if ({1'b0, crow} + 6'd1 >= nr) begin
                    r_next.scrolled = 1'b1;
                    idx_next = '0;
                    last_next = nrm1;
                    phys_next = rmap[0];
                    dir_del_next = 1'b1;
                    cnt_next = 8'd0;
                    state_next = tccb_pkg::S_SHIFT;
                  end else begin
                    crow_next = crow + RW'(1);
                    if (cmd.op == tccb_pkg::OP_PUT) state_next = tccb_pkg::S_DISP;
                  end
                  if (cmd.op == tccb_pkg::OP_PUT && state_next == tccb_pkg::S_DISP)
                    cmd_next.op = tccb_pkg::OP_PUT;
                end else begin
                  we = 1'b1;
                  waddr = {rmap[crow], ccol[CW-1:0]};
                  wdata = cmd.ch;
                  r_next.drawn_valid = 1'b1;
                  r_next.drawn_row = crow;
                  r_next.drawn_col = ccol[CW-1:0];
                  r_next.drawn_char = cmd.ch;
                  ccol_next = ccol + 8'd1;
                end
              end
              tccb_pkg::OP_RETURN: ccol_next = 8'd0;
              tccb_pkg::OP_BACKSPACE: begin
                if (ccol == 8'd0 && crow != '0) begin
                  crow_next = crow - RW'(1);
                  cnt_next = 8'd0;
                  state_next = tccb_pkg::S_BSREAD;
                end else if (ccol != 8'd0) ccol_next = ccol - 8'd1;
              end
              tccb_pkg::OP_DEL, tccb_pkg::OP_INS: begin
                if ({1'b0, cmd.row} < nr) begin
                  dir_del_next = (cmd.op == tccb_pkg::OP_DEL);
                  if (cmd.op == tccb_pkg::OP_DEL) begin
                    idx_next = cmd.row;
                    phys_next = rmap[cmd.row];
                  end else begin
                    idx_next = nrm1;
                    phys_next = rmap[nrm1];
                  end
                  last_next = (cmd.op == tccb_pkg::OP_DEL) ? nrm1 : cmd.row;
                  cnt_next = 8'd0;
                  state_next = tccb_pkg::S_SHIFT;
                end
              end
              tccb_pkg::OP_CLR: begin
                sweep_next = '0;
                crow_next = '0;
                ccol_next = 8'd0;
                state_next = tccb_pkg::S_CLR;
              end
              default: state_next = tccb_pkg::S_DONE;
            endcase
            if (cmd.op == tccb_pkg::OP_PUT && ccol >= nc && state_next == tccb_pkg::S_SHIFT)
              cmd_next.opx = tccb_pkg::OPX_NONE;
          end
        endcase
      end
      tccb_pkg::S_SHIFT: begin
        if (idx == last) begin
          map_set = 1'b1;
          state_next = tccb_pkg::S_ZERO;
        end else begin
          map_shift = 1'b1;
          idx_next = dir_del ? idx + RW'(1) : idx - RW'(1);
        end
      end
      tccb_pkg::S_ZERO: begin
        we = 1'b1;
        cnt_next = cnt + 8'd1;
        if (cnt == 8'(tccb_pkg::MaxCols - 1))
          state_next = (cmd.op == tccb_pkg::OP_PUT) ? tccb_pkg::S_DISP : tccb_pkg::S_DONE;
      end
      tccb_pkg::S_CLR: begin
        we = 1'b1;
        waddr = sweep;
        sweep_next = sweep + 1'b1;
        if (sweep == '1) state_next = tccb_pkg::S_DONE;
      end
      tccb_pkg::S_BSREAD: begin
        raddr = {rmap[crow], cnt[CW-1:0]};
        state_next = tccb_pkg::S_BSWAIT;
      end
      tccb_pkg::S_BSWAIT: begin
        raddr = {rmap[crow], cnt[CW-1:0]};
        state_next = tccb_pkg::S_BSCHK;
      end
      tccb_pkg::S_BSCHK: begin
        if (cnt >= nc || rdata == 8'd0) begin
          if (cnt == 8'd0 && crow != '0) begin
            crow_next = crow - RW'(1);
            state_next = tccb_pkg::S_BSREAD;
          end else begin
            ccol_next = (cnt == 8'd0) ? 8'd0 : cnt - 8'd1;
            state_next = tccb_pkg::S_DONE;
          end
        end else begin
          cnt_next = cnt + 8'd1;
          state_next = tccb_pkg::S_BSREAD;
        end
      end
      tccb_pkg::S_RDWAIT: begin
        raddr = {rmap[cmd.row], cmd.col};
        state_next = tccb_pkg::S_RDOUT;
      end
      tccb_pkg::S_RDOUT: begin
        r_next.read_char = rdata;
        state_next = tccb_pkg::S_DONE;
      end
      tccb_pkg::S_DONE: begin
        r_next.cursor_row = crow;
        r_next.cursor_col = ccol;
        ov_next = 1'b1;
        state_next = tccb_pkg::S_IDLE;
      end
      default: state_next = tccb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    idx <= idx_next;
    last <= last_next;
    phys <= phys_next;
    cnt <= cnt_next;
    dir_del <= dir_del_next;
    r <= r_next;
    if (rst) begin
      state <= tccb_pkg::S_INIT;
      sweep <= '0;
      crow <= '0;
      ccol <= 8'd0;
      ov <= 1'b0;
      for (int i = 0; i < tccb_pkg::MaxRows; i++) rmap[i] <= RW'(i);
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      crow <= crow_next;
      ccol <= ccol_next;
      ov <= ov_next;
      if (map_shift) rmap[idx] <= dir_del ? rmap[idx + RW'(1)] : rmap[idx - RW'(1)];
      if (map_set) rmap[idx] <= phys;
    end
  end

  // the clear pass covers the whole store and starts with the cursor homed
  always_ff @(posedge clk) begin
    if (!rst && state == tccb_pkg::S_CLR && sweep == '0)
      assert (crow == '0 && ccol == 8'd0) else $error("clear pass without homed cursor");
  end
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> $past(state_next) == tccb_pkg::S_IDLE || state == tccb_pkg::S_IDLE)
    else $error("command taken while busy");
  a_ov_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && out_stall) |=> ov && $stable(r))
    else $error("stalled result changed");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    ov |-> r.cursor_col <= 8'(tccb_pkg::MaxCols))
    else $error("cursor column past limit");
endmodule

FILE: src/text_console_cell_buffer_unit.sv
// Top level of the text console cell buffer: config registers, front end and back end.
// Depends on tccb_pkg, tccb_front, tccb_back.
// After reset the block clears its 4096-cell store, one cell per cycle, before it takes
// the first item; up to two items queue in the front end meanwhile. Printable characters,
// newline and return without a scroll, cursor moves and unused modes go through the
// dispatch and done states only, and the back end takes no new item until it is back in
// idle. An in-range read adds a wait and an output state, and a printable character that
// wraps without a scroll passes dispatch twice. Delete line, insert line and scrolls
// rotate the row map one entry per cycle and then zero all 128 cells of the freed row.
// Backspace past column 0 scans earlier rows one cell at a time through the store's read
// port, with a read, a wait and a check state per cell. Clear sweeps all 4096 cells, one
// per cycle. A result is held until taken, and no new item starts before that.
module text_console_cell_buffer_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] mode,
  input  logic [7:0] char_code,
  input  logic [4:0] row,
  input  logic [6:0] col,
  output logic out_valid,
  input  logic out_stall,
  output logic drawn_valid,
  output logic [4:0] drawn_row,
  output logic [6:0] drawn_col,
  output logic [7:0] drawn_char,
  output logic scrolled,
  output logic [4:0] cursor_row_out,
  output logic [7:0] cursor_col_out,
  output logic [7:0] read_char,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [7:0] cols_in_use;
  logic [5:0] rows_in_use;
  logic q_valid, q_take;
  tccb_pkg::cmd_t q_cmd;
  tccb_pkg::res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {24'd0, cols_in_use} :
                  (paddr == 3'd4) ? {26'd0, rows_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= 8'd80;
      rows_in_use <= 6'd25;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) cols_in_use <= pwdata[7:0];
      if (paddr == 3'd4) rows_in_use <= pwdata[5:0];
    end
  end

  tccb_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .char_code, .row, .col,
    .q_valid, .q_take, .q_cmd
  );

  tccb_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_cmd,
    .cols_reg(cols_in_use), .rows_reg(rows_in_use),
    .out_valid, .out_stall, .res
  );

  assign drawn_valid = res.drawn_valid;
  assign drawn_row = res.drawn_row;
  assign drawn_col = res.drawn_col;
  assign drawn_char = res.drawn_char;
  assign scrolled = res.scrolled;
  assign cursor_row_out = res.cursor_row;
  assign cursor_col_out = res.cursor_col;
  assign read_char = res.read_char;
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for text_console_cell_buffer_unit: drives random console items
// and APB register writes, and checks every result against an in-bench console predictor.
// Depends on tccb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

  class console_scoreboard;
    logic [7:0] cells [tccb_pkg::MaxRows][tccb_pkg::MaxCols];
    logic [4:0] line_map [tccb_pkg::MaxRows];
    int cur_row, cur_col;
    logic [7:0] cols_reg;
    logic [5:0] rows_reg;
    tccb_pkg::res_t pending_q [$];
    int errors, accepted, drawn, scrolls, reads;

    function new();
      for (int r = 0; r < tccb_pkg::MaxRows; r++) begin
        line_map[r] = 5'(r);
        for (int c = 0; c < tccb_pkg::MaxCols; c++) cells[r][c] = 8'd0;
      end
      cur_row = 0;
      cur_col = 0;
      cols_reg = 8'd80;
      rows_reg = 6'd25;
    endfunction

    function int ncols();
      if (cols_reg < 1) return 1;
      if (cols_reg > tccb_pkg::MaxCols) return tccb_pkg::MaxCols;
      return cols_reg;
    endfunction

    function int nrows();
      if (rows_reg < 1) return 1;
      if (rows_reg > tccb_pkg::MaxRows) return tccb_pkg::MaxRows;
      return rows_reg;
    endfunction

    function void set_cfg(int idx, logic [31:0] val);
      if (idx == 0) cols_reg = val[7:0];
      else rows_reg = val[5:0];
    endfunction

    function void blank_line(int r);
      for (int c = 0; c < tccb_pkg::MaxCols; c++) cells[line_map[r]][c] = 8'd0;
    endfunction

    function void drop_line(int r, int nr);
      logic [4:0] freed;
      if (r >= nr) return;
      freed = line_map[r];
      for (int i = r; i + 1 < nr; i++) line_map[i] = line_map[i + 1];
      line_map[nr - 1] = freed;
      blank_line(nr - 1);
    endfunction

    function void open_line(int r, int nr);
      logic [4:0] freed;
      if (r >= nr) return;
      freed = line_map[nr - 1];
      for (int i = nr - 1; i > r; i--) line_map[i] = line_map[i - 1];
      line_map[r] = freed;
      blank_line(r);
    endfunction

    function bit line_feed(int nr);
      bit scr;
      scr = 0;
      if (cur_row + 1 >= nr) begin
        drop_line(0, nr);
        scr = 1;
      end else cur_row++;
      cur_col = 0;
      return scr;
    endfunction

    function int line_length(int r, int nc);
      for (int i = 0; i < nc; i++)
        if (cells[line_map[r]][i] == 8'd0) return i;
      return nc;
    endfunction

    function void note(logic [2:0] m, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
      tccb_pkg::res_t e;
      int nc, nr;
      nc = ncols();
      nr = nrows();
      e = '0;
      accepted++;
      if (cur_row >= nr) cur_row = nr - 1;
      if (cur_col > nc) cur_col = nc;
      case (m)
        tccb_pkg::ModePut: begin
          if (ch == tccb_pkg::ChNewline) e.scrolled = line_feed(nr);
          else if (ch == tccb_pkg::ChReturn) cur_col = 0;
          else if (ch == tccb_pkg::ChBackspace) begin
            while (cur_col < 1 && cur_row > 0) begin
              cur_row--;
              cur_col = line_length(cur_row, nc);
            end
            if (cur_col > 0) cur_col--;
          end else begin
            if (cur_col >= nc) e.scrolled = line_feed(nr);
            cells[line_map[cur_row]][cur_col % tccb_pkg::MaxCols] = ch;
            e.drawn_valid = 1'b1;
            e.drawn_row = 5'(cur_row);
            e.drawn_col = 7'(cur_col);
            e.drawn_char = ch;
            cur_col++;
          end
        end
        tccb_pkg::ModeDel: drop_line(r, nr);
        tccb_pkg::ModeIns: open_line(r, nr);
        tccb_pkg::ModeClr: begin
          for (int i = 0; i < tccb_pkg::MaxRows; i++)
            for (int j = 0; j < tccb_pkg::MaxCols; j++) cells[i][j] = 8'd0;
          cur_row = 0;
          cur_col = 0;
        end
        tccb_pkg::ModeMove: begin
          if (r < nr && c < nc) begin
            cur_row = r;
            cur_col = c;
          end
        end
        tccb_pkg::ModeRead: begin
          if (r < nr && c < nc) e.read_char = cells[line_map[r]][c];
        end
        default: ;
      endcase
      e.cursor_row = 5'(cur_row);
      e.cursor_col = 8'(cur_col);
      pending_q.push_back(e);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endfunction

    function void check(tccb_pkg::res_t g);
      tccb_pkg::res_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = pending_q.pop_front();
      if (g.drawn_valid) drawn++;
      if (g.scrolled) scrolls++;
      if (g.read_char != 0) reads++;
      if (g.drawn_valid !== e.drawn_valid) report("drawn_valid", g.drawn_valid, e.drawn_valid);
      if (g.drawn_row !== e.drawn_row) report("drawn_row", g.drawn_row, e.drawn_row);
      if (g.drawn_col !== e.drawn_col) report("drawn_col", g.drawn_col, e.drawn_col);
      if (g.drawn_char !== e.drawn_char) report("drawn_char", g.drawn_char, e.drawn_char);
      if (g.scrolled !== e.scrolled) report("scrolled", g.scrolled, e.scrolled);
      if (g.cursor_row !== e.cursor_row) report("cursor_row", g.cursor_row, e.cursor_row);
      if (g.cursor_col !== e.cursor_col) report("cursor_col", g.cursor_col, e.cursor_col);
      if (g.read_char !== e.read_char) report("read_char", g.read_char, e.read_char);
    endfunction
  endclass

  localparam int StallLimit = 60000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] mode;
  logic [7:0] char_code;
  logic [4:0] row;
  logic [6:0] col;
  logic drawn_valid, scrolled;
  logic [4:0] drawn_row, cursor_row_out;
  logic [6:0] drawn_col;
  logic [7:0] drawn_char, cursor_col_out, read_char;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  console_scoreboard sb;
  bit quiet, hold_req;
  int idle_cycles;

  text_console_cell_buffer_unit u_dut (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (out_valid && !out_stall)
        sb.check('{drawn_valid, drawn_row, drawn_col, drawn_char, scrolled,
                   cursor_row_out, cursor_col_out, read_char});
      if (in_valid && !in_stall) sb.note(mode, char_code, row, col);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(logic [2:0] m, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    char_code <= ch;
    row <= r;
    col <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_cfg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random();
    int p, q, nr, nc;
    logic [2:0] m;
    logic [7:0] ch;
    logic [4:0] r;
    logic [6:0] c;
    nr = sb.nrows();
    nc = sb.ncols();
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    ch = 8'($urandom);
    r = 5'($urandom);
    c = 7'($urandom);
    if (p < 55) begin
      m = tccb_pkg::ModePut;
      if (q < 10) ch = tccb_pkg::ChNewline;
      else if (q < 15) ch = tccb_pkg::ChReturn;
      else if (q < 25) ch = tccb_pkg::ChBackspace;
    end else if (p < 60) m = tccb_pkg::ModeDel;
    else if (p < 65) m = tccb_pkg::ModeIns;
    else if (p < 66) m = tccb_pkg::ModeClr;
    else if (p < 78) m = tccb_pkg::ModeMove;
    else if (p < 96) m = tccb_pkg::ModeRead;
    else m = 3'($urandom_range(6, 7));
    if ((m == tccb_pkg::ModeMove || m == tccb_pkg::ModeRead || m == tccb_pkg::ModeDel ||
         m == tccb_pkg::ModeIns) && q < 80) begin
      r = 5'($urandom_range(0, nr - 1));
      c = 7'($urandom_range(0, nc - 1));
    end
    send(m, ch, r, c);
  endtask

  int cfg_cols [8] = '{80, 1, 128, 5, 128, 1, 0, 40};
  int cfg_rows [8] = '{25, 1, 32, 3, 1, 32, 0, 8};

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = tccb_pkg::ModePut;
    char_code = 8'd0;
    row = 5'd0;
    col = 7'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    idle_cycles = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send(tccb_pkg::ModeRead, 8'd0, 5'd0, 7'd0);
    send(tccb_pkg::ModeClr, 8'd0, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, 8'd65, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, 8'd0, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, 8'd255, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, tccb_pkg::ChNewline, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, tccb_pkg::ChBackspace, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, tccb_pkg::ChReturn, 5'd0, 7'd0);
    send(tccb_pkg::ModeRead, 8'd0, 5'd0, 7'd2);
    send(tccb_pkg::ModeMove, 8'd0, 5'd24, 7'd79);
    send(tccb_pkg::ModeMove, 8'd0, 5'd25, 7'd0);
    send(tccb_pkg::ModeMove, 8'd0, 5'd0, 7'd80);
    send(tccb_pkg::ModeRead, 8'd0, 5'd31, 7'd127);
    send(tccb_pkg::ModePut, 8'd66, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, 8'd67, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, tccb_pkg::ChNewline, 5'd0, 7'd0);
    send(tccb_pkg::ModeDel, 8'd0, 5'd0, 7'd0);
    send(tccb_pkg::ModeIns, 8'd0, 5'd3, 7'd0);
    send(tccb_pkg::ModeDel, 8'd0, 5'd31, 7'd0);
    send(tccb_pkg::ModeIns, 8'd0, 5'd25, 7'd0);
    send(3'd6, 8'hFF, 5'd31, 7'd127);
    send(3'd7, 8'h00, 5'd0, 7'd0);
    send(tccb_pkg::ModePut, 8'h7F, 5'd0, 7'd0);
    send(tccb_pkg::ModeRead, 8'd0, 5'd23, 7'd0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      apb_write(0, ph == 6 ? $urandom_range(1, 128) : cfg_cols[ph]);
      apb_write(1, ph == 6 ? $urandom_range(1, 32) : cfg_rows[ph]);
      if (ph == 7) quiet = 1;
      for (int i = 0; i < 128; i++) begin
        if (ph == 2 && i == 20) hold_req = 1;
        send_random();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d items over 8 register settings: %0d cells drawn, %0d scrolls,",
             sb.accepted, sb.drawn, sb.scrolls);
    $display("%0d nonzero reads, with random stalls on both sides and one long hold",
             sb.reads);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
